>>> hw/rtl/csim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csim_pkg
// Shared widths, types and helpers of the cube surface index map.
// ----------------------------------------------------------------------------
package csim_pkg;

    localparam int DIM_W         = 11;
    localparam int CRD_W         = 10;
    localparam int IDX_W         = 30;
    localparam int CNT_W         = 31;
    localparam int RING_W        = 13;
    localparam int NXNY_W        = 22;
    localparam int CNTI_W        = 34;
    localparam int ACC_W         = 33;
    localparam int OFF_W         = 14;
    localparam int QUO_W         = 30;
    localparam int MAX_DIM_DEF   = 1024;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        CFG_SIZE_X    = 2'd0,
        CFG_SIZE_Y    = 2'd1,
        CFG_SIZE_Z    = 2'd2,
        CFG_KEEP_INT  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_FULL = 2'd0,
        K_BOT  = 2'd1,
        K_TOP  = 2'd2,
        K_RING = 2'd3
    } t_kind;

    typedef struct packed {
        logic                mode;
        logic                bad;
        t_kind               kind;
        logic [CRD_W-1:0]    cx;
        logic [CRD_W-1:0]    cy;
        logic [ACC_W-1:0]    acc;
        logic [20:0]         prod_b;
        logic [22:0]         prod_c;
        logic [OFF_W-1:0]    roff;
        logic                ring_div;
        logic [RING_W-1:0]   rem;
        logic [QUO_W-1:0]    dq;
        logic [IDX_W-1:0]    idx;
        logic [CRD_W-1:0]    xo;
        logic [CRD_W-1:0]    yo;
        logic [CRD_W-1:0]    zo;
    } t_item;

    typedef struct packed {
        logic [RING_W-1:0] rem;
        logic [QUO_W-1:0]  dq;
    } t_div;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int max_dim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            res = DIM_W'(max_dim);
        end
        return res;
    endfunction

    // One restoring division step: bring in the next dividend bit, subtract
    // the divisor when it fits, and shift the quotient bit in at the bottom.
    function automatic t_div div_step(input logic [RING_W-1:0] rem, input logic [QUO_W-1:0] dq,
                                      input logic [RING_W-1:0] d);
        logic [RING_W:0] t;
        logic            ge;
        t_div            res;
        t       = {rem, dq[QUO_W-1]};
        ge      = (t >= {1'b0, d});
        t       = ge ? (t - {1'b0, d}) : t;
        res.rem = t[RING_W-1:0];
        res.dq  = {dq[QUO_W-2:0], ge};
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cube_surface_index_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cube_surface_index_map
// Converts box grid coordinates to compact point indices and back.
// ----------------------------------------------------------------------------
// Input words arrive on i_in_valid / o_in_stall and carry a mode bit with
// either coordinates (mode 0) or a point index (mode 1). Each accepted word
// yields exactly one result word on o_out_valid / i_out_stall, with the index
// or coordinates, the point count and an invalid flag.
// The grid sizes and the interior switch must be written through the plain
// write port only while no word is in flight; the block does not enforce it.
// After reset and after every register write o_in_stall stays high while the derived grid figures settle.
// The pipeline runs the index arithmetic, two 30-stage bit-serial division
// chains (one quotient bit per stage) and two decode stages into the result
// register. One word can enter every cycle while o_in_stall is low.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads sizes of 2 and surface numbering.
// ----------------------------------------------------------------------------
module cube_surface_index_map
    import csim_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [DIM_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_mode,
    input  wire logic [CRD_W-1:0]    i_coord_x,
    input  wire logic [CRD_W-1:0]    i_coord_y,
    input  wire logic [CRD_W-1:0]    i_coord_z,
    input  wire logic [IDX_W-1:0]    i_point_index,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [IDX_W-1:0]         o_index_out,
    output logic [CRD_W-1:0]         o_x_out,
    output logic [CRD_W-1:0]         o_y_out,
    output logic [CRD_W-1:0]         o_z_out,
    output logic [CNT_W-1:0]         o_point_count,
    output logic                     o_invalid
);

    logic [DIM_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic              r_keep_int;
    logic [2:0]        r_settle;
    logic [DIM_W-1:0]  r_nx, r_ny, r_nz;
    logic              r_surf;
    logic [NXNY_W-1:0] r_nxny;
    logic [RING_W-1:0] r_ring;
    logic [CNTI_W-1:0] r_cnt_full, r_cnt_ring, r_cnt;

    logic              w_adv;
    logic              w_take;
    t_item             n_s1, n_s2, n_s3, n_s4, n_p, n_f;
    t_item             r_s1, r_s2, r_s3, r_p;
    t_item             r_da [0:QUO_W];
    t_item             r_db [0:QUO_W];
    logic              r_v1, r_v2, r_v3, r_vp;
    logic [QUO_W:0]    r_vda, r_vdb;
    logic              r_out_vld;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x   <= DIM_W'(2);
            r_size_y   <= DIM_W'(2);
            r_size_z   <= DIM_W'(2);
            r_keep_int <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE_X:   r_size_x   <= i_cfg_data;
                CFG_SIZE_Y:   r_size_y   <= i_cfg_data;
                CFG_SIZE_Z:   r_size_z   <= i_cfg_data;
                CFG_KEEP_INT: r_keep_int <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input waits while the derived figures settle after a reset or a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_settle <= 3'(SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 3'd1;
        end
    end

    // Derived grid figures, recomputed from the size registers every cycle.
    always_ff @(posedge i_clk) begin
        r_nx       <= clamp_dim(r_size_x, MAX_DIM_DEF);
        r_ny       <= clamp_dim(r_size_y, MAX_DIM_DEF);
        r_nz       <= clamp_dim(r_size_z, MAX_DIM_DEF);
        r_surf     <= !r_keep_int && (r_nx > DIM_W'(1)) && (r_ny > DIM_W'(1))
                      && (r_nz > DIM_W'(1));
        r_nxny     <= NXNY_W'(r_nx) * NXNY_W'(r_ny);
        r_ring     <= (RING_W'(r_nx) << 1) + (RING_W'(r_ny) << 1) - RING_W'(4);
        r_cnt_full <= CNTI_W'(r_nxny) * CNTI_W'(r_nz);
        r_cnt_ring <= CNTI_W'(r_nz - DIM_W'(2)) * CNTI_W'(r_ring);
        r_cnt      <= r_surf ? ((CNTI_W'(r_nxny) << 1) + r_cnt_ring) : r_cnt_full;
    end

    assign w_adv      = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_adv || (r_settle != '0);
    assign w_take     = i_in_valid && !o_in_stall;

    // Stage 1: range checks, classification and the first products.
    always_comb begin
        logic edge_hit;
        n_s1      = '0;
        n_s1.mode = i_mode;
        n_s1.cx   = i_coord_x;
        n_s1.cy   = i_coord_y;
        edge_hit  = (i_coord_y == '0) || (DIM_W'(i_coord_y) == r_ny - DIM_W'(1))
                    || (i_coord_x == '0) || (DIM_W'(i_coord_x) == r_nx - DIM_W'(1));
        if (!i_mode) begin
            if (!r_surf) begin
                n_s1.kind = K_FULL;
            end else if (i_coord_z == '0) begin
                n_s1.kind = K_BOT;
            end else if (DIM_W'(i_coord_z) == r_nz - DIM_W'(1)) begin
                n_s1.kind = K_TOP;
            end else begin
                n_s1.kind = K_RING;
            end
            n_s1.bad = (DIM_W'(i_coord_x) >= r_nx) || (DIM_W'(i_coord_y) >= r_ny)
                       || (DIM_W'(i_coord_z) >= r_nz) || ((n_s1.kind == K_RING) && !edge_hit);
            n_s1.acc    = ACC_W'(r_ny) * ACC_W'(i_coord_z);
            n_s1.prod_b = 21'(r_nx) * 21'(i_coord_y);
            n_s1.prod_c = 23'(r_ring) * 23'(i_coord_z - CRD_W'(1));
            if (i_coord_y == '0) begin
                n_s1.roff = OFF_W'(i_coord_x);
            end else if (DIM_W'(i_coord_y) == r_ny - DIM_W'(1)) begin
                n_s1.roff = OFF_W'(r_nx) + OFF_W'(i_coord_x);
            end else if (i_coord_x == '0) begin
                n_s1.roff = (OFF_W'(r_nx) << 1) + OFF_W'(i_coord_y) - OFF_W'(1);
            end else begin
                n_s1.roff = (OFF_W'(r_nx) << 1) + OFF_W'(r_ny) + OFF_W'(i_coord_y)
                            - OFF_W'(3);
            end
        end else begin
            n_s1.bad = (CNTI_W'(i_point_index) >= r_cnt);
            if (!r_surf) begin
                n_s1.kind = K_FULL;
                n_s1.acc  = ACC_W'(i_point_index);
            end else if (NXNY_W'(i_point_index) < r_nxny && i_point_index < IDX_W'(r_nxny)) begin
                n_s1.kind = K_BOT;
                n_s1.acc  = ACC_W'(i_point_index);
            end else if (ACC_W'(i_point_index) < (ACC_W'(r_nxny) << 1)) begin
                n_s1.kind = K_TOP;
                n_s1.acc  = ACC_W'(i_point_index) - ACC_W'(r_nxny);
            end else begin
                n_s1.kind = K_RING;
                n_s1.acc  = ACC_W'(i_point_index) - (ACC_W'(r_nxny) << 1);
            end
        end
    end

    // Stage 2: sums of the face and ring indices.
    always_comb begin
        n_s2 = r_s1;
        if (!r_s1.mode) begin
            case (r_s1.kind)
                K_FULL: n_s2.acc = r_s1.acc + ACC_W'(r_s1.cy);
                K_BOT:  n_s2.acc = ACC_W'(r_s1.prod_b) + ACC_W'(r_s1.cx);
                K_TOP:  n_s2.acc = ACC_W'(r_nxny) + ACC_W'(r_s1.prod_b) + ACC_W'(r_s1.cx);
                K_RING: n_s2.acc = (ACC_W'(r_nxny) << 1) + ACC_W'(r_s1.prod_c)
                                   + ACC_W'(r_s1.roff);
                default: n_s2.acc = r_s1.acc;
            endcase
        end
    end

    // Stage 3: the x-stride product of the full grid.
    always_comb begin
        n_s3 = r_s2;
        if (!r_s2.mode && r_s2.kind == K_FULL) begin
            n_s3.acc = ACC_W'(r_nx) * ACC_W'(r_s2.acc[NXNY_W-1:0]);
        end
    end

    // Stage 4: final index, and the dividend for the first division.
    always_comb begin
        n_s4 = r_s3;
        if (!r_s3.mode && r_s3.kind == K_FULL) begin
            n_s4.acc = r_s3.acc + ACC_W'(r_s3.cx);
        end
        n_s4.idx      = (r_s3.mode || r_s3.bad) ? '0 : n_s4.acc[IDX_W-1:0];
        n_s4.dq       = n_s4.acc[QUO_W-1:0];
        n_s4.rem      = '0;
        n_s4.ring_div = r_s3.mode && (r_s3.kind == K_RING);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_da[0]  <= n_s4;
            r_p      <= n_p;
            r_db[0]  <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_vda[0] <= 1'b0;
            r_vp     <= 1'b0;
            r_vdb[0] <= 1'b0;
        end else if (w_adv) begin
            r_v1     <= w_take;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_vda[0] <= r_v3;
            r_vp     <= r_vda[QUO_W];
            r_vdb[0] <= r_vp;
        end
    end

    // Two bit-serial division chains, one quotient bit per stage.
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        t_div  w_sa, w_sb;
        t_item w_na, w_nb;
        assign w_sa = div_step(r_da[k].rem, r_da[k].dq,
                               r_da[k].ring_div ? r_ring : RING_W'(r_nx));
        assign w_sb = div_step(r_db[k].rem, r_db[k].dq, RING_W'(r_ny));

        always_comb begin
            w_na     = r_da[k];
            w_na.rem = w_sa.rem;
            w_na.dq  = w_sa.dq;
            w_nb     = r_db[k];
            w_nb.rem = w_sb.rem;
            w_nb.dq  = w_sb.dq;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_da[k+1] <= w_na;
                r_db[k+1] <= w_nb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vda[k+1] <= 1'b0;
                r_vdb[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_vda[k+1] <= r_vda[k];
                r_vdb[k+1] <= r_vdb[k];
            end
        end
    end

    // Post stage: decode faces and rings from the first quotient and remainder.
    always_comb begin
        t_item            a;
        logic [OFF_W-1:0] j, nx2;
        a   = r_da[QUO_W];
        j   = OFF_W'(a.rem);
        nx2 = OFF_W'(r_nx) << 1;
        n_p = a;
        n_p.xo = '0;
        n_p.yo = '0;
        n_p.zo = '0;
        if (a.mode) begin
            case (a.kind)
                K_FULL: n_p.xo = a.rem[CRD_W-1:0];
                K_BOT: begin
                    n_p.xo = a.rem[CRD_W-1:0];
                    n_p.yo = a.dq[CRD_W-1:0];
                end
                K_TOP: begin
                    n_p.xo = a.rem[CRD_W-1:0];
                    n_p.yo = a.dq[CRD_W-1:0];
                    n_p.zo = CRD_W'(r_nz - DIM_W'(1));
                end
                K_RING: begin
                    n_p.zo = a.dq[CRD_W-1:0] + CRD_W'(1);
                    if (j < OFF_W'(r_nx)) begin
                        n_p.xo = j[CRD_W-1:0];
                    end else if (j < nx2) begin
                        n_p.xo = CRD_W'(j - OFF_W'(r_nx));
                        n_p.yo = CRD_W'(r_ny - DIM_W'(1));
                    end else if (j < nx2 + OFF_W'(r_ny) - OFF_W'(2)) begin
                        n_p.yo = CRD_W'(j - nx2 + OFF_W'(1));
                    end else begin
                        n_p.xo = CRD_W'(r_nx - DIM_W'(1));
                        n_p.yo = CRD_W'(j - nx2 - OFF_W'(r_ny) + OFF_W'(3));
                    end
                end
                default: ;
            endcase
        end
        n_p.rem = '0;
    end

    // Final stage: full-grid y and z from the second division, then flagging.
    always_comb begin
        n_f = r_db[QUO_W];
        if (n_f.mode && n_f.kind == K_FULL) begin
            n_f.yo = n_f.rem[CRD_W-1:0];
            n_f.zo = n_f.dq[CRD_W-1:0];
        end
        if (n_f.bad) begin
            n_f.idx = '0;
            n_f.xo  = '0;
            n_f.yo  = '0;
            n_f.zo  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vdb[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_index_out   <= n_f.idx;
            o_x_out       <= n_f.xo;
            o_y_out       <= n_f.yo;
            o_z_out       <= n_f.zo;
            o_point_count <= r_cnt[CNT_W-1:0];
            o_invalid     <= n_f.bad;
        end
    end

    assign o_out_valid = r_out_vld;

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid) |-> (o_index_out == '0 && o_x_out == '0
                                        && o_y_out == '0 && o_z_out == '0))
        else $error("flagged word carries nonzero fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

>>> sim/tb_cube_surface_index_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of cube_surface_index_map
// Drives coordinate and index lookups under several grid settings, predicts
// each result word in a local model and compares it field by field.
// ----------------------------------------------------------------------------
module tb_cube_surface_index_map
    import csim_pkg::*;
;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
        logic [CNT_W-1:0] count;
        logic             invalid;
    } t_lookup;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [1:0]       i_cfg_idx = '0;
    logic [DIM_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_mode = 1'b0;
    logic [CRD_W-1:0] i_coord_x = '0;
    logic [CRD_W-1:0] i_coord_y = '0;
    logic [CRD_W-1:0] i_coord_z = '0;
    logic [IDX_W-1:0] i_point_index = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [IDX_W-1:0] o_index_out;
    logic [CRD_W-1:0] o_x_out;
    logic [CRD_W-1:0] o_y_out;
    logic [CRD_W-1:0] o_z_out;
    logic [CNT_W-1:0] o_point_count;
    logic             o_invalid;

    cube_surface_index_map u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the grid registers.
    logic [DIM_W-1:0] grid_x = 11'd2;
    logic [DIM_W-1:0] grid_y = 11'd2;
    logic [DIM_W-1:0] grid_z = 11'd2;
    logic             grid_all = 1'b0;

    t_lookup pending_lookups[$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic longint unsigned eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic t_lookup predict_lookup(input logic m, input logic [CRD_W-1:0] cx,
                                               input logic [CRD_W-1:0] cy,
                                               input logic [CRD_W-1:0] cz,
                                               input logic [IDX_W-1:0] pi);
        longint unsigned nx, ny, nz, nxny, ring, cnt, idx, x, y, z, i, r, j, base;
        logic            surf, bad;
        t_lookup         res;
        nx = eff_dim(grid_x);
        ny = eff_dim(grid_y);
        nz = eff_dim(grid_z);
        surf = !grid_all && nx > 1 && ny > 1 && nz > 1;
        nxny = nx * ny;
        ring = surf ? 2 * nx + 2 * ny - 4 : 0;
        cnt = surf ? 2 * nxny + (nz - 2) * ring : nxny * nz;
        idx = 0; x = 0; y = 0; z = 0; bad = 1'b0;
        if (m == 1'b0) begin
            if (cx >= nx || cy >= ny || cz >= nz) bad = 1'b1;
            else if (!surf) idx = cx + nx * (cy + ny * cz);
            else if (cz == 0) idx = cx + nx * cy;
            else if (cz == nz - 1) idx = nxny + cx + nx * cy;
            else begin
                base = 2 * nxny + ring * (cz - 1);
                if (cy == 0) idx = base + cx;
                else if (cy == ny - 1) idx = base + nx + cx;
                else if (cx == 0) idx = base + 2 * nx + (cy - 1);
                else if (cx == nx - 1) idx = base + 2 * nx + (ny - 2) + (cy - 1);
                else bad = 1'b1;
            end
        end else begin
            i = pi;
            if (i >= cnt) bad = 1'b1;
            else if (!surf) begin
                x = i % nx; i = i / nx; y = i % ny; z = i / ny;
            end else if (i < nxny) begin
                x = i % nx; y = i / nx;
            end else if (i < 2 * nxny) begin
                i = i - nxny; x = i % nx; y = i / nx; z = nz - 1;
            end else begin
                r = i - 2 * nxny;
                j = r % ring;
                z = r / ring + 1;
                if (j < nx) begin
                    x = j;
                end else if (j < 2 * nx) begin
                    x = j - nx; y = ny - 1;
                end else if (j < 2 * nx + ny - 2) begin
                    y = 1 + j - 2 * nx;
                end else begin
                    x = nx - 1; y = 1 + j - 2 * nx - (ny - 2);
                end
            end
        end
        if (bad) begin
            idx = 0; x = 0; y = 0; z = 0;
        end
        res.index = idx[IDX_W-1:0];
        res.x = x[CRD_W-1:0];
        res.y = y[CRD_W-1:0];
        res.z = z[CRD_W-1:0];
        res.count = cnt[CNT_W-1:0];
        res.invalid = bad;
        return res;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        t_lookup got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_index_out, o_x_out, o_y_out, o_z_out, o_point_count, o_invalid};
            if (pending_lookups.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("Unexpected result word %h", got);
            end else begin
                want = pending_lookups.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("Mismatch (exp/act): idx %0d/%0d x %0d/%0d y %0d/%0d",
                                 want.index, got.index, want.x, got.x, want.y, got.y);
                        $display("    z %0d/%0d cnt %0d/%0d inv %0d/%0d",
                                 want.z, got.z, want.count, got.count,
                                 want.invalid, got.invalid);
                    end
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_lookup(input logic m, input logic [CRD_W-1:0] cx,
                               input logic [CRD_W-1:0] cy, input logic [CRD_W-1:0] cz,
                               input logic [IDX_W-1:0] pi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_coord_z <= cz;
        i_point_index <= pi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_lookups = {pending_lookups, predict_lookup(m, cx, cy, cz, pi)};
        n_sent++;
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx r, input logic [DIM_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (r)
            CFG_SIZE_X:   grid_x = v;
            CFG_SIZE_Y:   grid_y = v;
            CFG_SIZE_Z:   grid_z = v;
            CFG_KEEP_INT: grid_all = v[0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] sx, input logic [DIM_W-1:0] sy,
                            input logic [DIM_W-1:0] sz, input logic all_pts);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        write_reg(CFG_KEEP_INT, {10'd0, all_pts});
    endtask

    function automatic logic [CRD_W-1:0] pick_coord(input logic [DIM_W-1:0] sz);
        longint unsigned n;
        n = eff_dim(sz);
        case ($urandom_range(9))
            0: return '0;
            1: return CRD_W'(n - 1);
            2: return CRD_W'($urandom);
            3: return n < 1024 ? CRD_W'(n) : CRD_W'(1023);
            default: return CRD_W'($urandom_range(32'(n - 1)));
        endcase
    endfunction

    // Random mix of both modes, mostly inside the numbered set.
    task automatic random_lookups(input int n);
        t_lookup probe;
        logic [IDX_W-1:0] pi;
        repeat (n) begin
            probe = predict_lookup(1'b1, 0, 0, 0, 0);
            case ($urandom_range(7))
                0: pi = IDX_W'($urandom);
                1: pi = probe.count[IDX_W-1:0];
                2: pi = IDX_W'(probe.count - 1);
                default: pi = IDX_W'($urandom_range(32'(probe.count - 1)));
            endcase
            send_lookup(1'($urandom_range(1)), pick_coord(grid_x), pick_coord(grid_y),
                        pick_coord(grid_z), pi);
        end
    endtask

    task automatic test_directed();
        set_grid(11'd5, 11'd4, 11'd6, 1'b0);
        // Bottom, top, ring rows and columns, interior, outside.
        send_lookup(1'b0, 0, 0, 0, 0);
        send_lookup(1'b0, 4, 3, 5, 0);
        send_lookup(1'b0, 2, 0, 2, 0);
        send_lookup(1'b0, 2, 3, 2, 0);
        send_lookup(1'b0, 0, 2, 3, 0);
        send_lookup(1'b0, 4, 1, 4, 0);
        send_lookup(1'b0, 2, 2, 2, 0);
        send_lookup(1'b0, 5, 0, 0, 0);
        send_lookup(1'b0, 1023, 1023, 1023, 0);
        send_lookup(1'b1, 0, 0, 0, 0);
        send_lookup(1'b1, 0, 0, 0, 19);
        send_lookup(1'b1, 0, 0, 0, 20);
        send_lookup(1'b1, 0, 0, 0, 40);
        send_lookup(1'b1, 0, 0, 0, 131);
        send_lookup(1'b1, 0, 0, 0, 132);
        send_lookup(1'b1, 0, 0, 0, 30'h3FFFFFFF);
        drain_pipeline();
        // Size zero counts as one, oversize clamps, full numbering.
        set_grid(11'd0, 11'd2047, 11'd1025, 1'b1);
        send_lookup(1'b0, 0, 1023, 1023, 0);
        send_lookup(1'b1, 0, 0, 0, 30'd1048575);
        send_lookup(1'b1, 0, 0, 0, 30'd1048576);
        send_lookup(1'b0, 1, 0, 0, 0);
        drain_pipeline();
    endtask

    task automatic test_phase(input int idle, input int stall, input int n);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        random_lookups(n);
        drain_pipeline();
    endtask

    task automatic test_random_grids();
        int k;
        for (k = 0; k < 12; k++) begin
            case (k % 4)
                0: set_grid(DIM_W'($urandom_range(8)), DIM_W'($urandom_range(8)),
                            DIM_W'($urandom_range(8)), 1'($urandom_range(1)));
                1: set_grid(11'd1024, 11'd1024, 11'd1024, k[2]);
                2: set_grid(DIM_W'($urandom_range(2047)), DIM_W'($urandom_range(40)),
                            DIM_W'($urandom_range(2047)), 1'($urandom_range(1)));
                default: set_grid(11'd2, DIM_W'($urandom_range(2, 30)), 11'd1, 1'b0);
            endcase
            case (k % 4)
                0: test_phase(0, 0, 140);
                1: test_phase(69, 0, 140);
                2: test_phase(0, 69, 140);
                default: test_phase(20, 20, 140);
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset grid is 2x2x2 in surface mode.
        test_phase(0, 0, 20);
        test_directed();
        test_random_grids();
        $display("Checked %0d lookups over %0d sent, both modes, many grid shapes.",
                 n_checked, n_sent);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
